/* hw/rtl/fpba_pkg.sv */
// Shared types and constants for the fit-policy block allocator.
// No dependencies; the allocator core imports this package.
package fpba_pkg;

    // Table geometry.
    localparam int MAX_BLOCKS = 16;
    localparam int SIZE_BITS  = 16;
    localparam int IDX_W      = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int CNT_W      = $clog2(MAX_BLOCKS + 1);
    localparam int BCNT_W     = 5;
    localparam int LIM_W      = (CNT_W > BCNT_W) ? CNT_W : BCNT_W;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;
    localparam logic [CFG_IDX_W-1:0] CFG_FIT_MODE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_COUNT = 2'd1;

    // Fit policies; any other code behaves as first fit.
    localparam logic [1:0] MODE_FIRST = 2'd0;
    localparam logic [1:0] MODE_BEST  = 2'd1;
    localparam logic [1:0] MODE_WORST = 2'd2;

    // Item commands.
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_ALLOC = 1'b1;

    typedef struct packed {
        logic        cmd;
        logic [3:0]  block_index;
        logic [15:0] block_size;
        logic [15:0] request_size;
    } t_alloc_in;

    typedef struct packed {
        logic        granted;
        logic [3:0]  chosen_block;
        logic [15:0] remaining_after;
    } t_alloc_out;

endpackage

/* hw/rtl/fit_policy_block_allocator_core.sv */
// Fit-policy block allocator: free-size table, scan sequencer and write-back.
// Depends on fpba_pkg for item types, codes and table geometry.
//
// Channel   Direction  Handshake                       Payload
// item in   in         start high and busy low         i_item (t_alloc_in)
// result    out        o_result_strobe, one cycle      o_result (t_alloc_out)
// config    in         i_cfg_valid and o_cfg_ready     i_cfg_index, i_cfg_data
//
// A load item leaves busy low. An allocate item scans the first N entries,
// where N is block_count capped at MAX_BLOCKS (with a count of zero it reports
// not granted at once, and busy stays low then): one table read per entry
// through the single read port, a registered read, then a write-back state on
// the shared subtractor.
// Reset clears the sequencer, control and config registers; payload registers and table contents stay undefined.
// The receiver cannot stall: each result shows for exactly one cycle.
module fit_policy_block_allocator_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    input  fpba_pkg::t_alloc_in                 i_item,
    output logic                                busy,
    output logic                                o_result_strobe,
    output fpba_pkg::t_alloc_out                o_result,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [fpba_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [fpba_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import fpba_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_WB   = 2'd2;

    logic [SIZE_BITS-1:0] r_table [MAX_BLOCKS];

    logic [1:0]           r_state, n_state;
    logic [1:0]           r_fit_mode;
    logic [BCNT_W-1:0]    r_block_count;
    logic [SIZE_BITS-1:0] r_req, n_req;
    logic [CNT_W-1:0]     r_lim, n_lim;
    logic [IDX_W-1:0]     r_addr, n_addr;
    logic                 r_issue, n_issue;
    logic                 r_rd_vld, r_rd_last;
    logic [IDX_W-1:0]     r_rd_idx;
    logic [SIZE_BITS-1:0] r_rd_data;
    logic                 r_found, n_found;
    logic [IDX_W-1:0]     r_pick, n_pick;
    logic [SIZE_BITS-1:0] r_best, n_best;
    logic                 r_out_vld, n_out_vld;
    t_alloc_out           r_out, n_out;

    logic                 accept;
    logic                 load_wr;
    logic [LIM_W-1:0]     bc_ext;
    logic [LIM_W-1:0]     lim_sat;
    logic                 qualifies;
    logic                 take;
    logic                 at_last;
    logic [SIZE_BITS-1:0] diff;

    assign busy        = (r_state != ST_IDLE) || !i_rst_n;
    assign o_cfg_ready = i_rst_n;
    assign accept      = start && !busy;
    assign load_wr     = accept && (i_item.cmd == CMD_LOAD)
                         && ({5'd0, i_item.block_index} < 9'(MAX_BLOCKS));

    // Search limit is the block count saturated to the table depth.
    assign bc_ext  = LIM_W'(r_block_count);
    assign lim_sat = (bc_ext > LIM_W'(MAX_BLOCKS)) ? LIM_W'(MAX_BLOCKS) : bc_ext;

    assign at_last = (r_addr == IDX_W'(r_lim - CNT_W'(1)));

    // Shared compare: does the entry just read fit, and should it replace the pick.
    assign qualifies = (r_rd_data >= r_req);
    always_comb begin
        take = 1'b0;
        if (r_rd_vld && qualifies) begin
            if (!r_found) begin
                take = 1'b1;
            end else if (r_fit_mode == MODE_BEST) begin
                take = (r_rd_data < r_best);
            end else if (r_fit_mode == MODE_WORST) begin
                take = (r_rd_data > r_best);
            end
        end
    end

    // Shared subtractor for the write-back.
    assign diff = r_best - r_req;

    // Sequencer.
    always_comb begin
        n_state   = r_state;
        n_req     = r_req;
        n_lim     = r_lim;
        n_addr    = r_addr;
        n_issue   = r_issue;
        n_found   = r_found;
        n_pick    = r_pick;
        n_best    = r_best;
        n_out_vld = 1'b0;
        n_out     = r_out;
        case (r_state)
            ST_IDLE: begin
                if (accept && (i_item.cmd == CMD_ALLOC)) begin
                    n_req   = SIZE_BITS'(i_item.request_size);
                    n_lim   = CNT_W'(lim_sat);
                    n_addr  = '0;
                    n_found = 1'b0;
                    if (lim_sat == '0) begin
                        // Nothing to search: report not granted at once.
                        n_out_vld = 1'b1;
                        n_out     = '0;
                    end else begin
                        n_issue = 1'b1;
                        n_state = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (r_issue) begin
                    if (at_last) begin
                        n_issue = 1'b0;
                    end else begin
                        n_addr = r_addr + IDX_W'(1);
                    end
                end
                if (take) begin
                    n_found = 1'b1;
                    n_pick  = r_rd_idx;
                    n_best  = r_rd_data;
                end
                if (r_rd_vld && r_rd_last) begin
                    n_state = ST_WB;
                end
            end
            ST_WB: begin
                n_out_vld = 1'b1;
                if (r_found) begin
                    n_out.granted         = 1'b1;
                    n_out.chosen_block    = 4'(r_pick);
                    n_out.remaining_after = 16'(diff);
                end else begin
                    n_out = '0;
                end
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_issue   <= 1'b0;
            r_rd_vld  <= 1'b0;
            r_found   <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_issue   <= n_issue;
            r_rd_vld  <= (r_state == ST_SCAN) && r_issue;
            r_found   <= n_found;
            r_out_vld <= n_out_vld;
        end
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fit_mode    <= MODE_FIRST;
            r_block_count <= BCNT_W'(16);
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == CFG_FIT_MODE) begin
                r_fit_mode <= i_cfg_data[1:0];
            end else if (i_cfg_index == CFG_BLOCK_COUNT) begin
                r_block_count <= i_cfg_data[BCNT_W-1:0];
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_req     <= n_req;
        r_lim     <= n_lim;
        r_addr    <= n_addr;
        r_pick    <= n_pick;
        r_best    <= n_best;
        r_out     <= n_out;
        r_rd_idx  <= r_addr;
        r_rd_last <= at_last;
    end

    // Table write port: loads while idle, charged entry on write-back.
    always_ff @(posedge i_clk) begin
        if (load_wr) begin
            r_table[IDX_W'(i_item.block_index)] <= SIZE_BITS'(i_item.block_size);
        end else if ((r_state == ST_WB) && r_found) begin
            r_table[r_pick] <= diff;
        end
    end

    // Table read port, registered.
    always_ff @(posedge i_clk) begin
        r_rd_data <= r_table[r_addr];
    end

    assign o_result_strobe = r_out_vld;
    assign o_result        = r_out;

endmodule

/* tb/tb.sv */
// Self-checking testbench for fit_policy_block_allocator_core: fit policies, counts and edge cases.
// A queue-fed driver and a clocked monitor check each grant against an in-bench allocation table.
// Depends on fpba_pkg for the item and result types, command codes and register indexes.
module tb;
    import fpba_pkg::*;

    // Fit code with no policy of its own; the block treats it as first fit.
    localparam logic [1:0] MODE_SPARE = 2'd3;

    // Quiet cycles before a register write; longer than the longest allocation.
    localparam int SETTLE_CYCLES = 24;
    // Number of queued operations at the end that go out without idle gaps.
    localparam int CALM_TAIL = 300;
    localparam int RANDOM_ITEMS = 1850;
    localparam int REPORT_LIMIT = 10;

    typedef enum logic {OP_ITEM, OP_CFG} t_op_kind;

    typedef struct {
        t_op_kind                kind;
        t_alloc_in               item;
        logic [CFG_IDX_W-1:0]    reg_index;
        logic [CFG_DATA_W-1:0]   reg_data;
    } t_pending_op;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    start = 1'b0;
    t_alloc_in               i_item = '0;
    logic                    busy;
    logic                    o_result_strobe;
    t_alloc_out              o_result;
    logic                    i_cfg_valid = 1'b0;
    logic                    o_cfg_ready;
    logic [CFG_IDX_W-1:0]    i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]   i_cfg_data = '0;

    fit_policy_block_allocator_core u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .i_item          (i_item),
        .busy            (busy),
        .o_result_strobe (o_result_strobe),
        .o_result        (o_result),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Stimulus queue, the allocation table copy and the grants still owed by the block.
    t_pending_op         pending_ops[$];
    t_alloc_out          expected_grants[$];
    logic [15:0]         free_sizes[MAX_BLOCKS];
    logic [1:0]          fit_policy = MODE_FIRST;
    logic [BCNT_W-1:0]   searched_count = 5'd16;

    int   idle_cycles = 0;
    int   quiet_wait = 0;
    int   gap_left = 0;
    logic stim_done = 1'b0;
    int   mismatch_count = 0;

    // Picks the block the policy selects, charges it and returns the grant.
    function automatic t_alloc_out charge_allocation(input logic [15:0] req);
        t_alloc_out res;
        int         limit;
        int         pick;
        bit         found;
        res   = '0;
        found = 1'b0;
        pick  = 0;
        limit = (searched_count > MAX_BLOCKS) ? MAX_BLOCKS : int'(searched_count);
        for (int j = 0; j < limit; j++) begin
            if (free_sizes[j] >= req) begin
                if (!found) begin
                    found = 1'b1;
                    pick  = j;
                end else if (fit_policy == MODE_BEST && free_sizes[j] < free_sizes[pick]) begin
                    pick = j;
                end else if (fit_policy == MODE_WORST && free_sizes[j] > free_sizes[pick]) begin
                    pick = j;
                end
            end
        end
        if (found) begin
            free_sizes[pick]    = free_sizes[pick] - req;
            res.granted         = 1'b1;
            res.chosen_block    = pick[3:0];
            res.remaining_after = free_sizes[pick];
        end
        return res;
    endfunction

    task automatic flag_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT) begin
            $display("[%0t] %s", $realtime, msg);
        end
    endtask

    // Queue builders; in load and allocate items the fields that the command ignores still carry random bits.
    task automatic add_load(input int idx, input int size);
        t_pending_op op;
        op.kind              = OP_ITEM;
        op.item.cmd          = CMD_LOAD;
        op.item.block_index  = idx[3:0];
        op.item.block_size   = size[15:0];
        op.item.request_size = 16'($urandom);
        op.reg_index         = '0;
        op.reg_data          = '0;
        pending_ops.push_back(op);
    endtask

    task automatic add_alloc(input int req);
        t_pending_op op;
        op.kind              = OP_ITEM;
        op.item.cmd          = CMD_ALLOC;
        op.item.block_index  = 4'($urandom);
        op.item.block_size   = 16'($urandom);
        op.item.request_size = req[15:0];
        op.reg_index         = '0;
        op.reg_data          = '0;
        pending_ops.push_back(op);
    endtask

    task automatic add_cfg(input logic [CFG_IDX_W-1:0] idx, input int data);
        t_pending_op op;
        op.kind      = OP_CFG;
        op.item      = '0;
        op.reg_index = idx;
        op.reg_data  = data[CFG_DATA_W-1:0];
        pending_ops.push_back(op);
    endtask

    // Driver: raises start or a register write, with random idle bursts between items outside the calm tail.
    // Register writes wait until the block is quiet and no grant is outstanding.
    always @(posedge i_clk) begin : driver
        logic        nxt_start;
        logic        nxt_cfg;
        t_pending_op op;
        if (!i_rst_n) begin
            start       <= 1'b0;
            i_cfg_valid <= 1'b0;
            gap_left    <= 0;
            quiet_wait  <= 0;
            stim_done   <= 1'b0;
        end else begin
            nxt_start = start && busy;
            nxt_cfg   = i_cfg_valid && !o_cfg_ready;
            if (!nxt_start && !nxt_cfg) begin
                if (gap_left != 0) begin
                    gap_left <= gap_left - 1;
                end else if (pending_ops.size() != 0) begin
                    if (pending_ops[0].kind == OP_CFG) begin
                        if (idle_cycles >= SETTLE_CYCLES && quiet_wait >= SETTLE_CYCLES) begin
                            op = pending_ops.pop_front();
                            i_cfg_index <= op.reg_index;
                            i_cfg_data  <= op.reg_data;
                            nxt_cfg = 1'b1;
                        end
                    end else if (pending_ops.size() > CALM_TAIL && $urandom_range(0, 5) == 0) begin
                        gap_left <= $urandom_range(1, 7);
                    end else begin
                        op = pending_ops.pop_front();
                        i_item <= op.item;
                        nxt_start = 1'b1;
                    end
                end
            end
            quiet_wait  <= nxt_start ? 0 : ((quiet_wait < 1000) ? quiet_wait + 1 : quiet_wait);
            start       <= nxt_start;
            i_cfg_valid <= nxt_cfg;
            stim_done   <= (pending_ops.size() == 0) && !nxt_start && !nxt_cfg;
        end
    end

    // Monitor: checks each grant, then follows accepted items and register writes.
    always @(posedge i_clk) begin : monitor
        t_alloc_out want;
        if (!i_rst_n) begin
            idle_cycles <= 0;
        end else begin
            if (o_result_strobe) begin
                if (expected_grants.size() == 0) begin
                    flag_mismatch($sformatf("unexpected result: granted=%0d block=%0d remaining=%0d",
                                            o_result.granted, o_result.chosen_block,
                                            o_result.remaining_after));
                end else begin
                    want = expected_grants.pop_front();
                    if (o_result.granted !== want.granted) begin
                        flag_mismatch($sformatf("granted: expected %0d, got %0d",
                                                want.granted, o_result.granted));
                    end
                    if (o_result.chosen_block !== want.chosen_block) begin
                        flag_mismatch($sformatf("chosen_block: expected %0d, got %0d",
                                                want.chosen_block, o_result.chosen_block));
                    end
                    if (o_result.remaining_after !== want.remaining_after) begin
                        flag_mismatch($sformatf("remaining_after: expected %0d, got %0d",
                                                want.remaining_after, o_result.remaining_after));
                    end
                end
            end
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == CFG_FIT_MODE) begin
                    fit_policy = i_cfg_data[1:0];
                end else if (i_cfg_index == CFG_BLOCK_COUNT) begin
                    searched_count = i_cfg_data[BCNT_W-1:0];
                end
            end
            if (start && !busy) begin
                if (i_item.cmd == CMD_LOAD) begin
                    free_sizes[i_item.block_index] = i_item.block_size;
                end else begin
                    expected_grants.push_back(charge_allocation(i_item.request_size));
                end
            end
            if (expected_grants.size() == 0 && !busy && !start) begin
                idle_cycles <= (idle_cycles < 1000) ? idle_cycles + 1 : idle_cycles;
            end else begin
                idle_cycles <= 0;
            end
        end
    end

    // Stimulus: directed corner cases, then phases of random items under changing settings.
    initial begin
        logic [1:0] phase_mode[8];
        int         phase_count[8];
        int         random_items;
        int         phase;
        int         burst;
        int         wait_cnt;
        int         leftover;

        phase_mode  = '{MODE_FIRST, MODE_BEST, MODE_WORST, MODE_SPARE,
                        MODE_BEST, MODE_WORST, MODE_FIRST, MODE_BEST};
        phase_count = '{16, 1, 31, 16, 16, 2, 0, 17};

        // Every entry is loaded before any search can reach it.
        add_load(0, 16'hFFFF);
        add_load(1, 0);
        for (int i = 2; i < MAX_BLOCKS; i++) begin
            add_load(i, (i * 97) % 1000 + 100);
        end

        // Zero request, a full-size grant, then the same request failing.
        add_alloc(0);
        add_alloc(16'hFFFF);
        add_alloc(16'hFFFF);
        add_cfg(CFG_FIT_MODE, MODE_BEST);
        add_alloc(150);
        add_cfg(CFG_FIT_MODE, MODE_WORST);
        add_alloc(1);
        add_cfg(CFG_FIT_MODE, MODE_SPARE);
        add_alloc(5);
        // An empty search never grants; an oversized count is clipped to the table.
        add_cfg(CFG_BLOCK_COUNT, 0);
        add_alloc(1);
        add_cfg(CFG_BLOCK_COUNT, 31);
        add_alloc(3);
        add_cfg(CFG_BLOCK_COUNT, 1);
        add_cfg(CFG_FIT_MODE, MODE_BEST);
        add_alloc(0);

        random_items = 0;
        phase = 0;
        while (random_items < RANDOM_ITEMS) begin
            if (phase < 8) begin
                add_cfg(CFG_FIT_MODE, phase_mode[phase]);
                add_cfg(CFG_BLOCK_COUNT, phase_count[phase]);
            end else begin
                add_cfg(CFG_FIT_MODE, $urandom_range(0, 3));
                case ($urandom_range(0, 7))
                    0: add_cfg(CFG_BLOCK_COUNT, $urandom_range(17, 31));
                    1: add_cfg(CFG_BLOCK_COUNT, 0);
                    default: add_cfg(CFG_BLOCK_COUNT, $urandom_range(1, 16));
                endcase
            end
            burst = $urandom_range(60, 140);
            for (int k = 0; k < burst; k++) begin
                if ($urandom_range(0, 9) < 3) begin
                    add_load($urandom_range(0, 15),
                             ($urandom_range(0, 7) == 0) ? $urandom_range(0, 65535)
                                                         : $urandom_range(0, 2000));
                end else begin
                    case ($urandom_range(0, 9))
                        0: add_alloc(0);
                        1: add_alloc($urandom_range(0, 65535));
                        default: add_alloc($urandom_range(1, 600));
                    endcase
                end
            end
            random_items += burst;
            phase++;
        end

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait for the queue to empty, then for the block to go quiet.
        @(posedge i_clk);
        while (!stim_done) @(posedge i_clk);
        wait_cnt = 0;
        while (idle_cycles < SETTLE_CYCLES && wait_cnt < 2000) begin
            @(posedge i_clk);
            wait_cnt++;
        end
        leftover = expected_grants.size();
        if (leftover != 0) begin
            $display("results never produced: %0d", leftover);
        end

        if (mismatch_count == 0 && leftover == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Watchdog, several times the slowest legal run.
    initial begin
        #5000000;
        $display("Mismatches found");
        $finish;
    end

endmodule

/* sim.f */
hw/rtl/fpba_pkg.sv
hw/rtl/fit_policy_block_allocator_core.sv
tb/tb.sv
